### rtl/asp_pkg.sv
package asp_pkg;

   // Coordinate and register width, fixed by the word format.
   localparam int unsigned COORD_W = 13;
   localparam int unsigned SUM_W = COORD_W + 1;
   localparam int unsigned MAX_SHELVES_DEF = 64;

   localparam logic [COORD_W-1:0] ATLAS_WIDTH_RST = COORD_W'(1024);
   localparam logic [COORD_W-1:0] ATLAS_HEIGHT_RST = COORD_W'(1024);

   localparam int unsigned CSR_IDX_W = 1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ATLAS_WIDTH = 1'b0,
      CSR_ATLAS_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      KIND_PACK = 1'b0,
      KIND_CLEAR = 1'b1
   } kind_type;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

endpackage

### rtl/asp_if.sv
interface asp_req_if;
   import asp_pkg::*;
   logic valid;
   logic ready;
   logic kind;
   logic [COORD_W-1:0] rect_width;
   logic [COORD_W-1:0] rect_height;
   modport source (output valid, kind, rect_width, rect_height, input ready);
   modport sink (input valid, kind, rect_width, rect_height, output ready);
endinterface

interface asp_rsp_if;
   import asp_pkg::*;
   logic valid;
   logic ready;
   logic ok;
   logic [COORD_W-1:0] place_x;
   logic [COORD_W-1:0] place_y;
   modport source (output valid, ok, place_x, place_y, input ready);
   modport sink (input valid, ok, place_x, place_y, output ready);
endinterface

interface asp_csr_if;
   import asp_pkg::*;
   logic valid;
   logic ready;
   logic [CSR_IDX_W-1:0] index;
   logic [COORD_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### rtl/asp_ram.sv
module asp_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### rtl/atlas_shelf_packer_top.sv
// First-fit shelf packer for a texture atlas. A pack word walks the shelf table
// in order, one shelf per clock out of a single-port-read RAM, and is placed on
// the first shelf where it fits; otherwise a new shelf opens at the greatest
// shelf top plus the word's height. The scan of a pack ends at the first shelf
// that fits or at the last shelf in use; a clear word or a word wider than the
// atlas is answered without a scan. A new word is taken once the scan of the
// previous one is done and the output register is empty or being read in that
// cycle, so a held result stalls the request side. The user must write the atlas
// size registers through the csr port only while the block is idle; the block
// itself does not enforce this. Both reset to 1024.
module atlas_shelf_packer_top #(
   parameter int unsigned MAX_SHELVES = asp_pkg::MAX_SHELVES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   asp_req_if.sink req_if,
   asp_rsp_if.source rsp_if,
   asp_csr_if.sink csr_if
);
   import asp_pkg::*;

   localparam int unsigned IDX_W = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
   localparam int unsigned CNT_W = $clog2(MAX_SHELVES + 1);
   localparam int unsigned ENTRY_W = 2 * COORD_W;

   state_type state_ff, state_in;
   logic [COORD_W-1:0] atlas_width_ff, atlas_height_ff;
   logic [CNT_W-1:0] shelf_count_ff, shelf_count_in;
   logic [CNT_W-1:0] chk_idx_ff, chk_idx_in;
   logic [SUM_W-1:0] max_y_ff, max_y_in;
   logic root_zero_ff, root_zero_in;
   logic [COORD_W-1:0] width_ff, width_in, height_ff, height_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_ok_ff, rsp_ok_in;
   logic [COORD_W-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   logic ram_we;
   logic [IDX_W-1:0] ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

   logic req_fire, rsp_fire, too_wide;
   logic [COORD_W-1:0] cur_top, cur_nx;
   logic [SUM_W-1:0] top_h, nx_w, cand_y;
   logic [SUM_W:0] new_bot;
   logic fits, last, table_full;
   logic [CNT_W-1:0] chk_next;

   asp_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_SHELVES)
   ) u_shelf_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   // A word may enter while the previous result is still held, provided it
   // drains in this cycle or the slot is empty; no scan produces a result
   // before the slot has freed up.
   assign req_if.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign req_fire = req_if.valid && req_if.ready;
   assign rsp_fire = rsp_valid_ff && rsp_if.ready;
   assign too_wide = req_if.rect_width > atlas_width_ff;

   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.ok = rsp_ok_ff;
   assign rsp_if.place_x = rsp_x_ff;
   assign rsp_if.place_y = rsp_y_ff;

   // Shelf 0 always sits at the top edge; its free x reads zero until the
   // first placement on it after reset or clear.
   assign cur_top = (chk_idx_ff == '0) ? '0 : ram_rdata[ENTRY_W-1:COORD_W];
   assign cur_nx = ((chk_idx_ff == '0) && root_zero_ff) ? '0 : ram_rdata[COORD_W-1:0];
   assign top_h = {1'b0, cur_top} + {1'b0, height_ff};
   assign nx_w = {1'b0, cur_nx} + {1'b0, width_ff};
   assign fits = (top_h <= {1'b0, atlas_height_ff}) && (nx_w <= {1'b0, atlas_width_ff});
   assign cand_y = (max_y_ff > top_h) ? max_y_ff : top_h;
   assign new_bot = {1'b0, cand_y} + {2'b00, height_ff};
   assign chk_next = chk_idx_ff + CNT_W'(1);
   assign last = (chk_next == shelf_count_ff);
   assign table_full = (shelf_count_ff == CNT_W'(MAX_SHELVES));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_if.kind == KIND_PACK) && !too_wide) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (fits || last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      shelf_count_in = shelf_count_ff;
      chk_idx_in = chk_idx_ff;
      max_y_in = max_y_ff;
      root_zero_in = root_zero_ff;
      width_in = width_ff;
      height_in = height_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_fire;
      rsp_ok_in = rsp_ok_ff;
      rsp_x_in = rsp_x_ff;
      rsp_y_in = rsp_y_ff;
      ram_we = 1'b0;
      ram_waddr = chk_idx_ff[IDX_W-1:0];
      ram_wdata = {cur_top, nx_w[COORD_W-1:0]};
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               width_in = req_if.rect_width;
               height_in = req_if.rect_height;
               chk_idx_in = '0;
               max_y_in = '0;
               if (req_if.kind == KIND_CLEAR) begin
                  shelf_count_in = CNT_W'(1);
                  root_zero_in = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_ok_in = 1'b1;
                  rsp_x_in = '0;
                  rsp_y_in = '0;
               end else if (too_wide) begin
                  rsp_valid_in = 1'b1;
                  rsp_ok_in = 1'b0;
                  rsp_x_in = '0;
                  rsp_y_in = '0;
               end
            end
         end
         ST_SCAN: begin
            chk_idx_in = chk_next;
            max_y_in = cand_y;
            if (fits) begin
               ram_we = 1'b1;
               if (chk_idx_ff == '0) begin
                  root_zero_in = 1'b0;
               end
               rsp_valid_in = 1'b1;
               rsp_ok_in = 1'b1;
               rsp_x_in = cur_nx;
               rsp_y_in = cur_top;
            end else if (last) begin
               rsp_valid_in = 1'b1;
               if (table_full || (new_bot > {2'b00, atlas_height_ff})) begin
                  rsp_ok_in = 1'b0;
                  rsp_x_in = '0;
                  rsp_y_in = '0;
               end else begin
                  ram_we = 1'b1;
                  ram_waddr = shelf_count_ff[IDX_W-1:0];
                  ram_wdata = {cand_y[COORD_W-1:0], width_ff};
                  shelf_count_in = chk_next + CNT_W'(1);
                  rsp_ok_in = 1'b1;
                  rsp_x_in = '0;
                  rsp_y_in = cand_y[COORD_W-1:0];
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign ram_raddr = chk_idx_in[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         atlas_width_ff <= ATLAS_WIDTH_RST;
         atlas_height_ff <= ATLAS_HEIGHT_RST;
         shelf_count_ff <= CNT_W'(1);
         root_zero_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         shelf_count_ff <= shelf_count_in;
         root_zero_ff <= root_zero_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid && csr_if.ready) begin
            case (csr_if.index)
               CSR_ATLAS_WIDTH: atlas_width_ff <= csr_if.data;
               CSR_ATLAS_HEIGHT: atlas_height_ff <= csr_if.data;
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      max_y_ff <= max_y_in;
      width_ff <= width_in;
      height_ff <= height_in;
      rsp_ok_ff <= rsp_ok_in;
      rsp_x_ff <= rsp_x_in;
      rsp_y_ff <= rsp_y_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (shelf_count_ff != '0) && (shelf_count_ff <= CNT_W'(MAX_SHELVES)))
      else $error("shelf count out of range");

   a_scan_in_table: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (chk_idx_ff < shelf_count_ff))
      else $error("scan index beyond shelf count");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (rsp_valid_ff || (state_ff == ST_SCAN)))
      else $error("accepted word neither answered nor scanning");

   a_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> ((state_ff == ST_SCAN) && rsp_valid_in))
      else $error("shelf write without a result");

   a_scan_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !(rsp_valid_ff && !rsp_fire && rsp_valid_in && (fits || last)))
      else $error("result slot busy at end of scan");
endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import asp_pkg::*;

   localparam int unsigned SHELF_SLOTS = MAX_SHELVES_DEF;
   localparam int unsigned QUIET_LIMIT = 4000;
   localparam int unsigned DRAIN_CYCLES = SHELF_SLOTS + 8;
   localparam int unsigned N_PHASES = 6;
   localparam int unsigned WORDS_PER_PHASE = 265;

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      kind_type kind;
      coord_type rect_w;
      coord_type rect_h;
   } rect_word_type;

   typedef struct packed {
      logic ok;
      coord_type x;
      coord_type y;
   } placement_type;

   logic clock = 1'b0;
   logic reset;

   asp_req_if req_if();
   asp_rsp_if rsp_if();
   asp_csr_if csr_if();

   atlas_shelf_packer_top #(
      .MAX_SHELVES(SHELF_SLOTS)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_if(csr_if)
   );

   rect_word_type pending_words[$];
   placement_type expected_places[$];
   placement_type head_place;

   // Shadow copy of the atlas: size registers and the shelf table.
   int unsigned atlas_w;
   int unsigned atlas_h;
   coord_type shelf_x[SHELF_SLOTS];
   coord_type shelf_y[SHELF_SLOTS];
   int unsigned shelf_cnt;

   coord_type phase_w[N_PHASES] = '{13'd4096, 13'd1, 13'd8191, 13'd100, 13'd0, 13'd1024};
   coord_type phase_h[N_PHASES] = '{13'd4096, 13'd8191, 13'd1, 13'd300, 13'd4096, 13'd64};

   int unsigned send_gap_pct;
   int unsigned recv_stall_pct;
   int unsigned words_in = 0;
   int unsigned clears_in = 0;
   int unsigned results_out = 0;
   int unsigned refused = 0;
   int unsigned settings_used = 0;
   int unsigned deepest_table = 1;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;

   always #10 clock = ~clock;

   task automatic report_mismatch(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
   endtask

   task automatic queue_word(rect_word_type wd);
      pending_words.insert(pending_words.size(), wd);
   endtask

   function automatic placement_type place_rect(rect_word_type wd);
      placement_type res;
      int unsigned w;
      int unsigned h;
      int unsigned n;
      int unsigned new_y;
      res = '0;
      w = 32'(wd.rect_w);
      h = 32'(wd.rect_h);
      n = shelf_cnt;
      if (wd.kind == KIND_CLEAR) begin
         foreach (shelf_x[i]) begin
            shelf_x[i] = '0;
            shelf_y[i] = '0;
         end
         shelf_cnt = 1;
         res.ok = 1'b1;
         return res;
      end
      if (w > atlas_w) begin
         return res;
      end
      // First fit: the earliest shelf with room in both directions wins.
      for (int i = 0; i < n; i++) begin
         if (shelf_y[i] + h <= atlas_h && shelf_x[i] + w <= atlas_w) begin
            res.ok = 1'b1;
            res.x = shelf_x[i];
            res.y = shelf_y[i];
            shelf_x[i] = coord_type'(shelf_x[i] + w);
            return res;
         end
      end
      // The new shelf opens below the largest top plus this height.
      new_y = 0;
      for (int i = 0; i < n; i++) begin
         if (shelf_y[i] + h > new_y) begin
            new_y = shelf_y[i] + h;
         end
      end
      if (n >= SHELF_SLOTS || new_y + h > atlas_h) begin
         return res;
      end
      shelf_y[n] = coord_type'(new_y);
      shelf_x[n] = coord_type'(w);
      shelf_cnt = n + 1;
      res.ok = 1'b1;
      res.y = coord_type'(new_y);
      return res;
   endfunction

   // Request driver: a word stays on the bus until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            expected_places.insert(expected_places.size(),
               place_rect({kind_type'(req_if.kind), req_if.rect_width, req_if.rect_height}));
            words_in++;
            if (req_if.kind == KIND_CLEAR) begin
               clears_in++;
            end
            if (shelf_cnt > deepest_table) begin
               deepest_table = shelf_cnt;
            end
         end
         if (pending_words.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_if.valid <= 1'b1;
            req_if.kind <= pending_words[0].kind;
            req_if.rect_width <= pending_words[0].rect_w;
            req_if.rect_height <= pending_words[0].rect_h;
            void'(pending_words.pop_front());
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result monitor and receiver stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_out++;
            if (rsp_if.ok !== 1'b1) begin
               refused++;
            end
            if (expected_places.size() == 0) begin
               report_mismatch("result word with no request outstanding");
            end else begin
               head_place = expected_places.pop_front();
               if (rsp_if.ok !== head_place.ok) begin
                  report_mismatch($sformatf("ok %b, expected %b", rsp_if.ok, head_place.ok));
               end
               if (rsp_if.place_x !== head_place.x) begin
                  report_mismatch($sformatf("place_x %0d, expected %0d",
                     rsp_if.place_x, head_place.x));
               end
               if (rsp_if.place_y !== head_place.y) begin
                  report_mismatch($sformatf("place_y %0d, expected %0d",
                     rsp_if.place_y, head_place.y));
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("tb failed");
      $finish;
   end

   task automatic write_atlas_reg(csr_index_type idx, coord_type value);
      @(posedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      if (idx == CSR_ATLAS_WIDTH) begin
         atlas_w = 32'(value);
      end else begin
         atlas_h = 32'(value);
      end
   endtask

   task automatic wait_drained(int unsigned settle);
      do @(negedge clock);
      while (pending_words.size() != 0 || req_if.valid || expected_places.size() != 0);
      repeat (settle) @(negedge clock);
   endtask

   function automatic coord_type pick_size(int unsigned span);
      case ($urandom_range(11))
         0: return '0;
         1: return coord_type'(span);
         2: return coord_type'(span + 1);
         3: return coord_type'($urandom);
         default: return coord_type'($urandom_range(span / 6 + 1));
      endcase
   endfunction

   function automatic rect_word_type pack_word(int unsigned w, int unsigned h);
      return {KIND_PACK, coord_type'(w), coord_type'(h)};
   endfunction

   // Mostly ordinary packs sized to the atlas, with clears, full-table fills
   // and some full-range noise mixed in.
   task automatic queue_random(int unsigned n_words);
      int unsigned made;
      int unsigned sel;
      made = 0;
      while (made < n_words) begin
         sel = $urandom_range(99);
         if (sel < 3) begin
            queue_word({KIND_CLEAR, coord_type'($urandom), coord_type'($urandom)});
            made++;
         end else if (sel < 6) begin
            // Full-width rectangles: once shelf 0 is full each asks for a new shelf.
            queue_word({KIND_CLEAR, coord_type'(0), coord_type'(0)});
            repeat (SHELF_SLOTS + 6) begin
               queue_word(pack_word(atlas_w, $urandom_range(1)));
            end
            made += SHELF_SLOTS + 7;
         end else if (sel < 9) begin
            queue_word(pack_word($urandom, $urandom));
            made++;
         end else begin
            queue_word(pack_word(pick_size(atlas_w), pick_size(atlas_h)));
            made++;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.kind = KIND_PACK;
      req_if.rect_width = '0;
      req_if.rect_height = '0;
      rsp_if.ready = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_ATLAS_WIDTH;
      csr_if.data = '0;
      atlas_w = 32'(ATLAS_WIDTH_RST);
      atlas_h = 32'(ATLAS_HEIGHT_RST);
      shelf_cnt = 1;
      shelf_x[0] = '0;
      shelf_y[0] = '0;
      send_gap_pct = 7;
      recv_stall_pct = 49;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed words on the reset-sized 1024 x 1024 atlas.
      queue_word({KIND_CLEAR, coord_type'(0), coord_type'(0)});
      queue_word(pack_word(0, 0));
      queue_word(pack_word(1024, 0));
      queue_word(pack_word(1025, 1));
      queue_word(pack_word(8191, 8191));
      queue_word(pack_word(1, 1024));
      queue_word(pack_word(1, 1));
      queue_word(pack_word(0, 8191));
      queue_word(pack_word(4096, 4096));
      queue_word(pack_word(512, 1023));
      queue_word(pack_word(511, 1));
      queue_word({KIND_CLEAR, coord_type'(8191), coord_type'(8191)});
      queue_word(pack_word(1024, 1024));
      queue_word(pack_word(0, 0));
      queue_word(pack_word(1, 0));
      queue_word({KIND_CLEAR, coord_type'(0), coord_type'(0)});
      queue_word(pack_word(300, 200));
      queue_word(pack_word(300, 500));
      queue_word(pack_word(300, 900));
      queue_word(pack_word(700, 100));
      wait_drained(4);

      for (int p = 0; p < N_PHASES; p++) begin
         if (p < 2) begin
            send_gap_pct = 7;
            recv_stall_pct = 49;
         end else if (p < 4) begin
            send_gap_pct = 49;
            recv_stall_pct = 7;
         end else begin
            send_gap_pct = 0;
            recv_stall_pct = 0;
         end
         write_atlas_reg(CSR_ATLAS_WIDTH, phase_w[p]);
         write_atlas_reg(CSR_ATLAS_HEIGHT, phase_h[p]);
         settings_used++;
         @(negedge clock);
         queue_random(WORDS_PER_PHASE);
         wait_drained(4);
      end
      wait_drained(DRAIN_CYCLES);

      $display("Run covered %0d request words (%0d clears) and %0d result words, %0d refused.",
         words_in, clears_in, results_out, refused);
      $display("Atlas sizes written: %0d settings; deepest shelf table %0d of %0d.",
         settings_used, deepest_table, SHELF_SLOTS);
      if (mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

### atlas_shelf_packer_top.f
rtl/asp_pkg.sv
rtl/asp_if.sv
rtl/asp_ram.sv
rtl/atlas_shelf_packer_top.sv
tb/tb.sv
